FILE: src/pms_pkg.sv
package pms_pkg;

	// default data memory size in bytes
	localparam int MEM_BYTES_DEF = 1024 * 8;

	// one data word is eight bytes, little-endian
	localparam int WORD_BYTES = 8;
	localparam int OFF_W = 3;

	// status codes
	localparam logic [2:0] ST_AOK = 3'd0;
	localparam logic [2:0] ST_ADR = 3'd1;
	localparam logic [2:0] ST_BUB = 3'd4;

	// instruction codes that matter to this stage
	localparam logic [3:0] IC_NOP    = 4'd1;
	localparam logic [3:0] IC_RMMOVQ = 4'd4;
	localparam logic [3:0] IC_MRMOVQ = 4'd5;
	localparam logic [3:0] IC_CALL   = 4'd8;
	localparam logic [3:0] IC_RET    = 4'd9;
	localparam logic [3:0] IC_PUSHQ  = 4'd10;
	localparam logic [3:0] IC_POPQ   = 4'd11;

	// no destination register
	localparam logic [3:0] REG_NONE = 4'd15;

	// memory access request decoded from one instruction
	typedef struct packed {
		logic rd;
		logic wr;
		logic addr_a;
	} pms_access_t;

endpackage

FILE: src/pms_bank.sv
module pms_bank #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	// one byte lane: write or registered read at one row per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/pipeline_memory_stage.sv
// channel | signals                               | direction
// --------+---------------------------------------+----------
// input   | in_valid / in_ready, bubble, in_*     | into block
// output  | out_valid / out_ready, out_*          | out of block
//
// One request per cycle while the output is not stalled: input register, then the
// data memory access, then the result register (read data rotated on output).
// The data memory is eight byte-wide banks of MEM_BYTES/8 rows each.
// After reset a clearing pass zeroes one row of all banks per cycle, and
// in_ready stays low until it is done. A stalled result holds the pipeline;
// in_ready is low while the input register is full and cannot advance.
module pipeline_memory_stage #(
	parameter int MEM_BYTES = pms_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        bubble,
	input  logic [2:0]  in_status,
	input  logic [3:0]  in_icode,
	input  logic [3:0]  in_ifun,
	input  logic        in_cond,
	input  logic [63:0] in_val_e,
	input  logic [63:0] in_val_a,
	input  logic [3:0]  in_dst_e,
	input  logic [3:0]  in_dst_m,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	output logic [3:0]  out_icode,
	output logic [3:0]  out_ifun,
	output logic        out_cond,
	output logic [63:0] out_val_e,
	output logic [63:0] out_val_a,
	output logic [63:0] out_val_m,
	output logic [3:0]  out_dst_e,
	output logic [3:0]  out_dst_m
);

	import pms_pkg::*;

	localparam int ROWS = (MEM_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int ROW_W = $clog2(ROWS);
	localparam logic [63:0] LAST_ADDR = 64'(MEM_BYTES - WORD_BYTES);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	// clearing pass
	logic             clr_q;
	logic [ROW_W-1:0] clr_row_q;

	// stage 1
	logic        valid_s1;
	logic [2:0]  status_s1;
	logic [3:0]  icode_s1;
	logic [3:0]  ifun_s1;
	logic        cond_s1;
	logic [63:0] val_e_s1;
	logic [63:0] val_a_s1;
	logic [3:0]  dst_e_s1;
	logic [3:0]  dst_m_s1;

	// stage 2
	logic        valid_s2;
	logic [2:0]  status_s2;
	logic [3:0]  icode_s2;
	logic [3:0]  ifun_s2;
	logic        cond_s2;
	logic [63:0] val_e_s2;
	logic [63:0] val_a_s2;
	logic [3:0]  dst_e_s2;
	logic [3:0]  dst_m_s2;
	logic        rd_s2;
	logic [OFF_W-1:0] off_s2;

	logic             adv;
	pms_access_t      acc;
	logic [63:0]      addr;
	logic             addr_ok;
	logic [OFF_W-1:0] off;
	logic [ROW_W-1:0] base_row;
	logic [2:0]       status_nx;
	logic             rd_go;
	logic             wr_go;
	logic [7:0]       rdata [WORD_BYTES];

	// handshake
	assign adv = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !clr_q && (!valid_s1 || adv);
	assign out_valid = valid_s2;

	// zero the memory one row per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			if (clr_row_q == LAST_ROW) begin
				clr_q <= 1'b0;
			end else begin
				clr_row_q <= clr_row_q + 1'b1;
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture request, turning a bubble into a nop
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (bubble) begin
				status_s1 <= ST_BUB;
				icode_s1 <= IC_NOP;
				ifun_s1 <= 4'd0;
				cond_s1 <= 1'b0;
				val_e_s1 <= 64'd0;
				val_a_s1 <= 64'd0;
				dst_e_s1 <= REG_NONE;
				dst_m_s1 <= REG_NONE;
			end else begin
				status_s1 <= in_status;
				icode_s1 <= in_icode;
				ifun_s1 <= in_ifun;
				cond_s1 <= in_cond;
				val_e_s1 <= in_val_e;
				val_a_s1 <= in_val_a;
				dst_e_s1 <= in_dst_e;
				dst_m_s1 <= in_dst_m;
			end
		end
	end

	// decode the access
	always_comb begin
		acc = '0;
		unique case (icode_s1)
			IC_RMMOVQ, IC_PUSHQ, IC_CALL: acc.wr = 1'b1;
			IC_MRMOVQ: acc.rd = 1'b1;
			IC_POPQ, IC_RET: begin
				acc.rd = 1'b1;
				acc.addr_a = 1'b1;
			end
			default: acc = '0;
		endcase
	end

	// address select and bounds check
	always_comb begin
		if (acc.addr_a) begin
			addr = val_a_s1;
		end else if (acc.rd || acc.wr) begin
			addr = val_e_s1;
		end else begin
			addr = 64'd0;
		end
		addr_ok = !addr[63] && (addr <= LAST_ADDR);
		off = addr[OFF_W-1:0];
		base_row = addr[ROW_W+OFF_W-1:OFF_W];
		status_nx = addr_ok ? status_s1 : ST_ADR;
		rd_go = acc.rd && addr_ok;
		wr_go = acc.wr && addr_ok;
	end

	// byte banks: a word spans base_row, wrapping into the next row
	for (genvar b = 0; b < WORD_BYTES; b++) begin : g_bank
		logic             wrap;
		logic [OFF_W-1:0] lane;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] bank_addr;
		logic [7:0]       wbyte;

		assign wrap = OFF_W'(b) < off;
		assign lane = OFF_W'(b) - off;
		assign row = base_row + ROW_W'(wrap);
		assign bank_addr = clr_q ? clr_row_q : row;
		assign wbyte = clr_q ? 8'd0 : val_a_s1[{lane, 3'b000} +: 8];

		pms_bank #(
			.DEPTH(ROWS),
			.AW(ROW_W)
		) u_bank (
			.clk(clk),
			.we(clr_q || (adv && wr_go)),
			.re(adv && rd_go),
			.addr(bank_addr),
			.wdata(wbyte),
			.rdata(rdata[b])
		);
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_nx;
			icode_s2 <= icode_s1;
			ifun_s2 <= ifun_s1;
			cond_s2 <= cond_s1;
			val_e_s2 <= val_e_s1;
			val_a_s2 <= val_a_s1;
			dst_e_s2 <= dst_e_s1;
			dst_m_s2 <= dst_m_s1;
			rd_s2 <= rd_go && (status_nx != ST_ADR);
			off_s2 <= off;
		end
	end

	// reassemble the read word from the banks
	for (genvar i = 0; i < WORD_BYTES; i++) begin : g_rd
		logic [OFF_W-1:0] src;

		assign src = off_s2 + OFF_W'(i);
		assign out_val_m[8*i +: 8] = rd_s2 ? rdata[src] : 8'd0;
	end

	assign out_status = status_s2;
	assign out_icode = icode_s2;
	assign out_ifun = ifun_s2;
	assign out_cond = cond_s2;
	assign out_val_e = val_e_s2;
	assign out_val_a = val_a_s2;
	assign out_dst_e = dst_e_s2;
	assign out_dst_m = dst_m_s2;

endmodule

FILE: dv/memory_stage_checker.sv
module memory_stage_checker #(
	parameter int MEM_BYTES = pms_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        bubble,
	input  logic [2:0]  in_status,
	input  logic [3:0]  in_icode,
	input  logic [3:0]  in_ifun,
	input  logic        in_cond,
	input  logic [63:0] in_val_e,
	input  logic [63:0] in_val_a,
	input  logic [3:0]  in_dst_e,
	input  logic [3:0]  in_dst_m,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  out_status,
	input  logic [3:0]  out_icode,
	input  logic [3:0]  out_ifun,
	input  logic        out_cond,
	input  logic [63:0] out_val_e,
	input  logic [63:0] out_val_a,
	input  logic [63:0] out_val_m,
	input  logic [3:0]  out_dst_e,
	input  logic [3:0]  out_dst_m,
	output int          fail_count,
	output int          outstanding
);
	import pms_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  icode;
		logic [3:0]  ifun;
		logic        cond;
		logic [63:0] val_e;
		logic [63:0] val_a;
		logic [63:0] val_m;
		logic [3:0]  dst_e;
		logic [3:0]  dst_m;
	} stage_result_t;

	// shadow copy of the data memory
	logic [7:0] shadow_mem [MEM_BYTES];

	// results still owed by the block, oldest first
	stage_result_t pending_results [$];

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	// apply one request to the shadow memory and work out its result
	function automatic stage_result_t memory_access(
		logic bub, logic [2:0] st, logic [3:0] ic, logic [3:0] fn, logic c,
		logic [63:0] ve, logic [63:0] va, logic [3:0] de, logic [3:0] dm
	);
		stage_result_t r;
		logic [63:0] addr;
		logic rd;
		logic wr;
		r.status = st;
		r.icode = ic;
		r.ifun = fn;
		r.cond = c;
		r.val_e = ve;
		r.val_a = va;
		r.val_m = '0;
		r.dst_e = de;
		r.dst_m = dm;
		rd = 1'b0;
		wr = 1'b0;
		addr = '0;
		// a bubble becomes a nop with bubble status
		if (bub) begin
			r.status = ST_BUB;
			r.icode = IC_NOP;
			r.ifun = '0;
			r.cond = 1'b0;
			r.val_e = '0;
			r.val_a = '0;
			r.dst_e = REG_NONE;
			r.dst_m = REG_NONE;
		end
		// access decode
		case (r.icode)
			IC_RMMOVQ, IC_PUSHQ, IC_CALL: begin
				wr = 1'b1;
				addr = r.val_e;
			end
			IC_MRMOVQ: begin
				rd = 1'b1;
				addr = r.val_e;
			end
			IC_POPQ, IC_RET: begin
				rd = 1'b1;
				addr = r.val_a;
			end
			default: ;
		endcase
		// the whole word must fit below the top of memory
		if (addr[63] || addr > 64'(MEM_BYTES - WORD_BYTES)) begin
			r.status = ST_ADR;
		end else begin
			for (int i = 0; i < WORD_BYTES; i++) begin
				if (rd)
					r.val_m[8*i +: 8] = shadow_mem[int'(addr) + i];
				if (wr)
					shadow_mem[int'(addr) + i] = r.val_a[8*i +: 8];
			end
		end
		if (r.status == ST_ADR)
			r.val_m = '0;
		return r;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch on %s: expected %h, got %h", field, want, got);
		end
	endtask

	// predict on each accepted request, compare each accepted result
	always @(posedge clk or negedge arst_n) begin
		stage_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEM_BYTES; i++)
				shadow_mem[i] = 8'h00;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				pending_results.push_back(memory_access(bubble, in_status, in_icode,
					in_ifun, in_cond, in_val_e, in_val_a, in_dst_e, in_dst_m));
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result with no request waiting: status %h icode %h",
							out_status, out_icode);
				end else begin
					want = pending_results.pop_front();
					check_field("status", 64'(want.status), 64'(out_status));
					check_field("icode", 64'(want.icode), 64'(out_icode));
					check_field("ifun", 64'(want.ifun), 64'(out_ifun));
					check_field("cond", 64'(want.cond), 64'(out_cond));
					check_field("val_e", want.val_e, out_val_e);
					check_field("val_a", want.val_a, out_val_a);
					check_field("val_m", want.val_m, out_val_m);
					check_field("dst_e", 64'(want.dst_e), 64'(out_dst_e));
					check_field("dst_m", 64'(want.dst_m), 64'(out_dst_m));
				end
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: dv/pipeline_memory_stage_tb.sv
module pipeline_memory_stage_tb;
	import pms_pkg::*;

	localparam int RANDOM_REQUESTS = 1550;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        bubble;
	logic [2:0]  in_status;
	logic [3:0]  in_icode;
	logic [3:0]  in_ifun;
	logic        in_cond;
	logic [63:0] in_val_e;
	logic [63:0] in_val_a;
	logic [3:0]  in_dst_e;
	logic [3:0]  in_dst_m;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  out_status;
	logic [3:0]  out_icode;
	logic [3:0]  out_ifun;
	logic        out_cond;
	logic [63:0] out_val_e;
	logic [63:0] out_val_a;
	logic [63:0] out_val_m;
	logic [3:0]  out_dst_e;
	logic [3:0]  out_dst_m;
	int          fail_count;
	int          outstanding;
	bit          in_quiet;
	bit          out_quiet;

	pipeline_memory_stage dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .bubble(bubble),
		.in_status(in_status), .in_icode(in_icode), .in_ifun(in_ifun),
		.in_cond(in_cond), .in_val_e(in_val_e), .in_val_a(in_val_a),
		.in_dst_e(in_dst_e), .in_dst_m(in_dst_m),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_status(out_status), .out_icode(out_icode), .out_ifun(out_ifun),
		.out_cond(out_cond), .out_val_e(out_val_e), .out_val_a(out_val_a),
		.out_val_m(out_val_m), .out_dst_e(out_dst_e), .out_dst_m(out_dst_m)
	);

	memory_stage_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .bubble(bubble),
		.in_status(in_status), .in_icode(in_icode), .in_ifun(in_ifun),
		.in_cond(in_cond), .in_val_e(in_val_e), .in_val_a(in_val_a),
		.in_dst_e(in_dst_e), .in_dst_m(in_dst_m),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_status(out_status), .out_icode(out_icode), .out_ifun(out_ifun),
		.out_cond(out_cond), .out_val_e(out_val_e), .out_val_a(out_val_a),
		.out_val_m(out_val_m), .out_dst_e(out_dst_e), .out_dst_m(out_dst_m),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// addresses mostly near both ends of memory so reads find earlier writes
	function automatic logic [63:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 64'($urandom_range(0, 127));
		else if (r < 75)
			return 64'($urandom_range(MEM_BYTES_DEF - 136, MEM_BYTES_DEF - WORD_BYTES));
		else if (r < 85)
			return 64'($urandom_range(MEM_BYTES_DEF - WORD_BYTES + 1, MEM_BYTES_DEF + 8));
		else if (r < 92)
			return random_word() | 64'h8000_0000_0000_0000;
		return random_word();
	endfunction

	// present one request after a random gap and hold it until accepted
	task automatic send_request(
		logic bub, logic [2:0] st, logic [3:0] ic, logic [3:0] fn, logic c,
		logic [63:0] ve, logic [63:0] va, logic [3:0] de, logic [3:0] dm
	);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bubble <= bub;
		in_status <= st;
		in_icode <= ic;
		in_ifun <= fn;
		in_cond <= c;
		in_val_e <= ve;
		in_val_a <= va;
		in_dst_e <= de;
		in_dst_m <= dm;
		do @(posedge clk); while (!in_ready);
	endtask

	// request side: reset, directed cases, then random traffic
	initial begin
		logic [3:0]  access_codes [6];
		logic [3:0]  ic;
		logic [2:0]  st;
		logic [63:0] ve;
		logic [63:0] va;
		logic        bub;
		access_codes[0] = IC_RMMOVQ;
		access_codes[1] = IC_MRMOVQ;
		access_codes[2] = IC_CALL;
		access_codes[3] = IC_RET;
		access_codes[4] = IC_PUSHQ;
		access_codes[5] = IC_POPQ;
		in_quiet = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		bubble <= 1'b0;
		in_status <= ST_AOK;
		in_icode <= IC_NOP;
		in_ifun <= '0;
		in_cond <= 1'b0;
		in_val_e <= '0;
		in_val_a <= '0;
		in_dst_e <= REG_NONE;
		in_dst_m <= REG_NONE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// bubble over a write must not touch memory
		send_request(1'b1, ST_AOK, IC_RMMOVQ, 4'hf, 1'b1, '1, '1, 4'h0, 4'h0);
		// write and read back at the bottom and at the last full word
		send_request(1'b0, ST_AOK, IC_RMMOVQ, 4'h0, 1'b0, 64'd0,
			64'h0123_4567_89ab_cdef, 4'h0, REG_NONE);
		send_request(1'b0, ST_AOK, IC_MRMOVQ, 4'h0, 1'b1, 64'd0, '0, REG_NONE, 4'h0);
		send_request(1'b0, ST_AOK, IC_PUSHQ, 4'h0, 1'b0, 64'(MEM_BYTES_DEF - WORD_BYTES),
			64'hfedc_ba98_7654_3210, 4'h4, REG_NONE);
		send_request(1'b0, ST_AOK, IC_POPQ, 4'h0, 1'b0, '1,
			64'(MEM_BYTES_DEF - WORD_BYTES), 4'h4, 4'hf);
		// unaligned call overlapping the first word, then ret reads the mix
		send_request(1'b0, ST_AOK, IC_CALL, 4'h0, 1'b1, 64'd4,
			64'haa55_aa55_0ff0_f00f, 4'h4, REG_NONE);
		send_request(1'b0, ST_AOK, IC_RET, 4'h0, 1'b1, '0, 64'd0, 4'h4, REG_NONE);
		// one byte past the last full word, and addresses with bit 63 set
		send_request(1'b0, ST_AOK, IC_RMMOVQ, 4'h0, 1'b0,
			64'(MEM_BYTES_DEF - WORD_BYTES + 1), '1, REG_NONE, REG_NONE);
		send_request(1'b0, ST_AOK, IC_MRMOVQ, 4'h0, 1'b0,
			64'(MEM_BYTES_DEF - WORD_BYTES + 1), '0, REG_NONE, 4'h3);
		send_request(1'b0, ST_AOK, IC_MRMOVQ, 4'h0, 1'b0, 64'h8000_0000_0000_0000,
			'0, REG_NONE, 4'h3);
		send_request(1'b0, ST_AOK, IC_POPQ, 4'h0, 1'b0, '0, '1, 4'h4, 4'h5);
		// non-ok status still accesses memory
		send_request(1'b0, 3'd2, IC_RMMOVQ, 4'h0, 1'b0, 64'd16,
			64'h1122_3344_5566_7788, REG_NONE, REG_NONE);
		send_request(1'b0, 3'd3, IC_MRMOVQ, 4'h0, 1'b0, 64'd16, '0, REG_NONE, 4'h2);
		send_request(1'b0, ST_ADR, IC_MRMOVQ, 4'h0, 1'b0, 64'd16, '0, REG_NONE, 4'h2);
		// no-access codes never raise an address error
		send_request(1'b0, ST_BUB, IC_NOP, 4'hf, 1'b1, '1, '1, 4'hf, 4'hf);
		for (int k = 0; k < 16; k++) begin
			if (!(4'(k) inside {IC_NOP, IC_RMMOVQ, IC_MRMOVQ, IC_CALL, IC_RET,
					IC_PUSHQ, IC_POPQ}))
				send_request(1'b0, 3'($urandom_range(0, 4)), 4'(k),
					4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
					random_word(), random_word(), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)));
		end

		// random traffic, mostly memory accesses
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 64 == 0)
				in_quiet = ($urandom_range(0, 3) == 0);
			bub = ($urandom_range(0, 99) < 5);
			if ($urandom_range(0, 99) < 65)
				ic = access_codes[$urandom_range(0, 5)];
			else
				ic = 4'($urandom_range(0, 15));
			st = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 4)) : ST_AOK;
			ve = random_word();
			va = random_word();
			if (ic == IC_POPQ || ic == IC_RET)
				va = pick_address();
			else if (ic inside {IC_RMMOVQ, IC_MRMOVQ, IC_PUSHQ, IC_CALL})
				ve = pick_address();
			send_request(bub, st, ic, 4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1)), ve, va, 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)));
		end
		in_valid <= 1'b0;

		// drain, then give the verdict
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls with quiet stretches
	initial begin
		int stall;
		int taken;
		taken = 0;
		out_quiet = 1'b0;
		out_ready <= 1'b0;
		forever begin
			if (taken % 64 == 0)
				out_quiet = ($urandom_range(0, 3) == 0);
			stall = out_quiet ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// watchdog
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
src/pms_pkg.sv
src/pms_bank.sv
src/pipeline_memory_stage.sv
dv/memory_stage_checker.sv
dv/pipeline_memory_stage_tb.sv
